FILE: sv/fw2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2_pkg
// Shared types and constants of the two-dimensional Fenwick rectangle unit.
// ----------------------------------------------------------------------------
package fw2_pkg;

   localparam int GRID_DEF = 64;
   localparam int COORD_W  = 6;
   localparam int DATA_W   = 32;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUM = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CSETUP,
      ST_CMUL,
      ST_CRD,
      ST_CWR,
      ST_QSETUP,
      ST_QWALK,
      ST_QDRAIN,
      ST_QMUL,
      ST_QACC,
      ST_FINISH
   } state_type;

   // One memory word holds the same cell of all four trees.
   typedef struct packed {
      logic [DATA_W-1:0] plain;
      logic [DATA_W-1:0] row_w;
      logic [DATA_W-1:0] col_w;
      logic [DATA_W-1:0] both_w;
   } tree_word_type;

   typedef struct packed {
      logic start;
      logic step;
      logic dir_up;
   } walk_ctl_type;

   typedef struct packed {
      logic cell_ok;
      logic last;
   } walk_stat_type;

endpackage

FILE: sv/fw2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2_req_if / fw2_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface fw2_req_if;
   import fw2_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [COORD_W-1:0]       row_lo;
   logic [COORD_W-1:0]       col_lo;
   logic [COORD_W-1:0]       row_hi;
   logic [COORD_W-1:0]       col_hi;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, command, row_lo, col_lo, row_hi, col_hi, value,
                   input ready);
   modport sink (input valid, command, row_lo, col_lo, row_hi, col_hi, value,
                 output ready);
endinterface

interface fw2_rsp_if;
   import fw2_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] total;
   modport source (output valid, total, input ready);
   modport sink (input valid, total, output ready);
endinterface

FILE: sv/fw2_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fw2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/fw2_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2_walk
// Index walker of a two-dimensional Fenwick tree, upward for point updates
// and downward for prefix queries, one tree cell per step.
// ----------------------------------------------------------------------------
module fw2_walk #(
   parameter int GRID = 64,
   parameter int CW   = 7
) (
   input  logic                   clock,
   input  fw2_pkg::walk_ctl_type  ctl,
   input  logic [CW-1:0]          start_r,
   input  logic [CW-1:0]          start_c,
   output logic [CW-1:0]          cur_i,
   output logic [CW-1:0]          cur_j,
   output fw2_pkg::walk_stat_type stat
);
   import fw2_pkg::*;

   logic [CW-1:0] i_ff, j_ff, c0_ff;
   logic [CW-1:0] i_in, j_in;
   logic          up_ff;
   logic [CW-1:0] lbi, lbj, inext, jnext;
   logic          row_end;

   // Next position along the walk.
   always_comb begin
      lbi = i_ff & (~i_ff + CW'(1));
      lbj = j_ff & (~j_ff + CW'(1));
      if (up_ff) begin
         inext   = i_ff + lbi;
         jnext   = j_ff + lbj;
         row_end = (jnext >= CW'(GRID));
         stat.last = row_end && (inext >= CW'(GRID));
      end else begin
         inext   = i_ff - lbi;
         jnext   = j_ff - lbj;
         row_end = (i_ff >= CW'(GRID)) || (jnext == '0);
         stat.last = row_end && (inext == '0);
      end
      stat.cell_ok = (i_ff < CW'(GRID)) && (j_ff < CW'(GRID)) &&
                     (i_ff != '0) && (j_ff != '0);
      if (row_end) begin
         i_in = inext;
         j_in = c0_ff;
      end else begin
         i_in = i_ff;
         j_in = jnext;
      end
   end

   // Position registers.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         i_ff  <= start_r;
         j_ff  <= start_c;
         c0_ff <= start_c;
         up_ff <= ctl.dir_up;
      end else if (ctl.step) begin
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   assign cur_i = i_ff;
   assign cur_j = j_ff;
endmodule

FILE: sv/fenwick_2d_rect_add_rect_sum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_rect_add_rect_sum_unit
// Rectangle add and rectangle sum over a grid held as four 2-D Fenwick trees
// in one wide memory.
// ----------------------------------------------------------------------------
//  Channel    Direction  Carries
//  req_chan   in         command, row_lo, col_lo, row_hi, col_hi, value
//  rsp_chan   out        total (zero for an add item)
//
// Every item is accepted in ST_IDLE and ends in a hand-over state, ST_FINISH,
// which waits while an earlier result still waits. An add item passes, for each
// corner inside the grid, through ST_CSETUP and ST_CMUL, then reads and writes
// back every tree cell it touches (ST_CRD, then ST_CWR); a skipped corner uses
// only ST_CSETUP. A sum item passes, for each prefix query, through ST_QSETUP,
// ST_QWALK, ST_QDRAIN, ST_QMUL and ST_QACC; a skipped query uses only ST_QSETUP.
// After reset a clearing pass writes zero to all 4**clog2(GRID) words (4096 at
// GRID = 64) before the first item is taken. A waiting result does not stop
// the next item from being accepted; only its final hand-over waits.
module fenwick_2d_rect_add_rect_sum_unit #(
   parameter int GRID = fw2_pkg::GRID_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fw2_req_if.sink   req_chan,
   fw2_rsp_if.source rsp_chan
);
   import fw2_pkg::*;

   localparam int IW = $clog2(GRID);
   localparam int CW = (IW + 1 > 7) ? IW + 1 : 7;
   localparam int AW = 2 * IW;
   localparam int TW = $bits(tree_word_type);

   state_type state_ff, state_in;

   logic [1:0]          k_ff;
   logic                cmd_ff;
   logic [CW-1:0]       rl_ff, cl_ff, rh_ff, ch_ff;
   logic [DATA_W-1:0]   v_ff, cv_ff, wr_ff, wc_ff, wb_ff, rm1_ff;
   logic [CW-1:0]       qr_ff, qc_ff;
   logic [2*CW-1:0]     rc_ff;
   logic                neg_ff, pend_ff;
   tree_word_type       sum_ff;
   logic [DATA_W-1:0]   m1_ff, m2_ff, m3_ff, total_ff;
   logic [AW-1:0]       clr_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_total_ff;

   logic [CW-1:0]       cur_r, cur_c, rlq, clq, walk_i, walk_j;
   logic                cur_neg, corner_skip, query_skip, last_k, rsp_free;
   walk_ctl_type        wctl;
   walk_stat_type       wstat;
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, cell_addr;
   tree_word_type       ram_wdata, ram_rdata;
   logic [DATA_W-1:0]   term;

   // Corner or query coordinates for the current step.
   always_comb begin
      rlq = (rl_ff == '0) ? '0 : rl_ff - CW'(1);
      clq = (cl_ff == '0) ? '0 : cl_ff - CW'(1);
      if (cmd_ff == CMD_ADD) begin
         unique case (k_ff)
            2'd0:    begin cur_r = rl_ff;          cur_c = cl_ff;          end
            2'd1:    begin cur_r = rh_ff + CW'(1); cur_c = ch_ff + CW'(1); end
            2'd2:    begin cur_r = rl_ff;          cur_c = ch_ff + CW'(1); end
            default: begin cur_r = rh_ff + CW'(1); cur_c = cl_ff;          end
         endcase
         cur_neg = k_ff[1];
      end else begin
         unique case (k_ff)
            2'd0:    begin cur_r = rh_ff; cur_c = ch_ff; end
            2'd1:    begin cur_r = rlq;   cur_c = ch_ff; end
            2'd2:    begin cur_r = rh_ff; cur_c = clq;   end
            default: begin cur_r = rlq;   cur_c = clq;   end
         endcase
         cur_neg = k_ff[0] ^ k_ff[1];
      end
      query_skip  = (cur_r == '0) || (cur_c == '0);
      corner_skip = query_skip || (cur_r >= CW'(GRID)) || (cur_c >= CW'(GRID));
      last_k      = (k_ff == 2'd3);
      rsp_free    = !rsp_valid_ff || rsp_chan.ready;
      cell_addr   = {walk_i[IW-1:0], walk_j[IW-1:0]};
      term        = m1_ff - m2_ff - m3_ff + sum_ff.both_w;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.command == CMD_SUM) ? ST_QSETUP : ST_CSETUP;
            end
         end
         ST_CSETUP: begin
            if (corner_skip) state_in = last_k ? ST_FINISH : ST_CSETUP;
            else state_in = ST_CMUL;
         end
         ST_CMUL:   state_in = ST_CRD;
         ST_CRD:    state_in = ST_CWR;
         ST_CWR: begin
            if (wstat.last) state_in = last_k ? ST_FINISH : ST_CSETUP;
            else state_in = ST_CRD;
         end
         ST_QSETUP: begin
            if (query_skip) state_in = last_k ? ST_FINISH : ST_QSETUP;
            else state_in = ST_QWALK;
         end
         ST_QWALK:  if (wstat.last) state_in = ST_QDRAIN;
         ST_QDRAIN: state_in = ST_QMUL;
         ST_QMUL:   state_in = ST_QACC;
         ST_QACC:   state_in = last_k ? ST_FINISH : ST_QSETUP;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the sequencer: walker and memory control.
   always_comb begin
      wctl.start  = 1'b0;
      wctl.step   = 1'b0;
      wctl.dir_up = (state_ff == ST_CSETUP);
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = cell_addr;
      ram_wdata   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         ST_CSETUP: wctl.start = !corner_skip;
         ST_QSETUP: wctl.start = !query_skip;
         ST_CRD:    ram_re = 1'b1;
         ST_CWR: begin
            ram_we           = 1'b1;
            ram_wdata.plain  = ram_rdata.plain  + cv_ff;
            ram_wdata.row_w  = ram_rdata.row_w  + wr_ff;
            ram_wdata.col_w  = ram_rdata.col_w  + wc_ff;
            ram_wdata.both_w = ram_rdata.both_w + wb_ff;
            wctl.step        = 1'b1;
         end
         ST_QWALK: begin
            ram_re    = wstat.cell_ok;
            wctl.step = 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == ST_QWALK) && wstat.cell_ok;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff   <= req_chan.command;
            rl_ff    <= CW'(req_chan.row_lo);
            cl_ff    <= CW'(req_chan.col_lo);
            rh_ff    <= CW'(req_chan.row_hi);
            ch_ff    <= CW'(req_chan.col_hi);
            v_ff     <= req_chan.value;
            k_ff     <= 2'd0;
            total_ff <= '0;
         end
         ST_CSETUP: begin
            cv_ff  <= cur_neg ? (DATA_W'(0) - v_ff) : v_ff;
            rm1_ff <= DATA_W'(cur_r) - DATA_W'(1);
            wr_ff  <= (DATA_W'(cur_r) - DATA_W'(1)) *
                      (cur_neg ? (DATA_W'(0) - v_ff) : v_ff);
            wc_ff  <= (DATA_W'(cur_c) - DATA_W'(1)) *
                      (cur_neg ? (DATA_W'(0) - v_ff) : v_ff);
            if (corner_skip) k_ff <= k_ff + 2'd1;
         end
         ST_CMUL:   wb_ff <= rm1_ff * wc_ff;
         ST_CWR:    if (wstat.last) k_ff <= k_ff + 2'd1;
         ST_QSETUP: begin
            qr_ff  <= cur_r;
            qc_ff  <= cur_c;
            rc_ff  <= (2*CW)'(cur_r) * (2*CW)'(cur_c);
            neg_ff <= cur_neg;
            sum_ff <= '0;
            if (query_skip) k_ff <= k_ff + 2'd1;
         end
         ST_QMUL: begin
            m1_ff <= DATA_W'(rc_ff) * sum_ff.plain;
            m2_ff <= DATA_W'(qc_ff) * sum_ff.row_w;
            m3_ff <= DATA_W'(qr_ff) * sum_ff.col_w;
         end
         ST_QACC: begin
            total_ff <= neg_ff ? (total_ff - term) : (total_ff + term);
            k_ff     <= k_ff + 2'd1;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_total_ff <= (cmd_ff == CMD_SUM) ? total_ff : '0;
            end
         end
         default: ;
      endcase
      // Sums of the tree words read along the current query walk.
      if (pend_ff) begin
         sum_ff.plain  <= sum_ff.plain  + ram_rdata.plain;
         sum_ff.row_w  <= sum_ff.row_w  + ram_rdata.row_w;
         sum_ff.col_w  <= sum_ff.col_w  + ram_rdata.col_w;
         sum_ff.both_w <= sum_ff.both_w + ram_rdata.both_w;
      end
   end

   // Tree walker.
   fw2_walk #(
      .GRID (GRID),
      .CW   (CW)
   ) u_walk (
      .clock   (clock),
      .ctl     (wctl),
      .start_r (cur_r),
      .start_c (cur_c),
      .cur_i   (walk_i),
      .cur_j   (walk_j),
      .stat    (wstat)
   );

   // Four trees side by side in one memory.
   fw2_ram #(
      .WIDTH (TW),
      .DEPTH (1 << AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cell_addr),
      .rd_data (ram_rdata)
   );

   // Channel ports.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.total = rsp_total_ff;
endmodule
